// ===== src/lir_pkg.sv =====
// Shared types and constants for the linear interpolation resampler.
package lir_pkg;

    // Field widths of the channels
    localparam int POINT_TIME_W  = 32;
    localparam int POINT_VALUE_W = 32;
    localparam int OUT_VALUE_W   = 32;
    localparam int OUT_INDEX_W   = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int MAX_OUT_W  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_START_TIME  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_TIME   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_OUTPUTS = 2'd2;

    // Register values after reset
    localparam logic [CFG_DATA_W-1:0] START_TIME_RST  = 32'd0;
    localparam logic [CFG_DATA_W-1:0] STEP_TIME_RST   = 32'd256;
    localparam logic [MAX_OUT_W-1:0]  MAX_OUTPUTS_RST = 16'hFFFF;

    // One source point
    typedef struct packed {
        logic [POINT_TIME_W-1:0]         point_time;
        logic signed [POINT_VALUE_W-1:0] point_value;
        logic                            first_point;
    } t_point;

    // One resampled output
    typedef struct packed {
        logic signed [OUT_VALUE_W-1:0] out_value;
        logic [OUT_INDEX_W-1:0]        out_index;
        logic                          last_of_run;
        logic                          cap_hit;
    } t_result;

endpackage

// ===== src/lir_if.sv =====
// Valid/ready stream interfaces for source points and resampled outputs.
interface lir_point_if import lir_pkg::*; ();
    logic   valid;
    logic   ready;
    t_point data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lir_result_if import lir_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== src/linear_interp_resampler_core.sv =====
// Linear interpolation resampler: top level with sequencer and shared mul/divide unit.
//
// Usage:
//   i_point  : source points (time Q24.8, signed value, first_point) in time order.
//   o_result : resampled values on the grid start_time + n*step_time, each with its
//              index in the record, a last-of-run flag and a per-point cap flag.
//   i_cfg_*  : write-only register port (start_time, step_time, max_outputs);
//              write only while the block is idle.
// Processing:
//   A point that starts a record, or goes back in time, is only evaluated and stored.
//   Otherwise each interpolated output of the item passes through the shared
//   one-bit-per-cycle restoring divider unless its quotient saturates;
//   outputs on a zero-width segment skip the multiply and divide.
//   A run cut short by the per-point cap adds one more divider pass to
//   skip the remaining grid times (remainder from the same divider).
//   One item is processed at a time; i_point.ready is high only between items.
// Reset: synchronous, active low; configuration registers return to their defaults and the
//   next point starts a new record.
// Stall: a finished output waits in the output register; the sequencer holds
//   its next output until that register is taken.
module linear_interp_resampler_core import lir_pkg::*; #(
    parameter int MAX_PER_SEGMENT = 64,
    parameter int VALUE_BITS      = 32,
    parameter int TIME_BITS       = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    lir_point_if.sink             i_point,
    lir_result_if.source          o_result,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    // Derived widths
    localparam int TW = (TIME_BITS < POINT_TIME_W) ? TIME_BITS : POINT_TIME_W;
    localparam int GW = TW + 1;               // grid time
    localparam int VW = VALUE_BITS;
    localparam int QB = VW + 1;               // quotient bits before saturation
    localparam int PW = VW + GW;              // product
    localparam int NW = PW + 1;               // product plus rounding half
    localparam int SW = (QB > TW) ? QB : TW;  // divider dividend shifter
    localparam int CW = $clog2(SW + 1);
    localparam int MW = $clog2(MAX_PER_SEGMENT + 1);
    localparam int RW = QB + 2;               // signed result before clamp

    localparam logic signed [RW-1:0] VMAX = {{(RW-VW+1){1'b0}}, {(VW-1){1'b1}}};
    localparam logic signed [RW-1:0] VMIN = ~VMAX;

    // Sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_EVAL = 4'd1;
    localparam logic [3:0] S_CAP  = 4'd2;
    localparam logic [3:0] S_TEST = 4'd3;
    localparam logic [3:0] S_ADD  = 4'd4;
    localparam logic [3:0] S_CHK  = 4'd5;
    localparam logic [3:0] S_DIV  = 4'd6;
    localparam logic [3:0] S_RES  = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;
    localparam logic [3:0] S_SKIP = 4'd9;

    // Configuration
    logic [CFG_DATA_W-1:0] r_start;
    logic [CFG_DATA_W-1:0] r_step;
    logic [MAX_OUT_W-1:0]  r_max;

    // Record state
    logic [3:0]           r_state;
    logic                 r_have_prev;
    logic [TW-1:0]        r_prev_time;
    logic signed [VW-1:0] r_prev_value;
    logic [GW-1:0]        r_grid;
    logic [MAX_OUT_W-1:0] r_count;

    // Current item
    logic [TW-1:0]        r_t1;
    logic signed [VW-1:0] r_v1;
    logic                 r_first;
    logic [MW-1:0]        r_n;
    logic                 r_cap;

    // Arithmetic unit
    logic [PW-1:0]        r_prod;
    logic [NW-1:0]        r_num;
    logic                 r_neg;
    logic                 r_ovf;
    logic                 r_skip;
    logic [TW-1:0]        r_den;
    logic [TW-1:0]        r_rem;
    logic [SW-1:0]        r_sh;
    logic [QB-1:0]        r_quo;
    logic [CW-1:0]        r_dcnt;
    logic signed [VW-1:0] r_res;

    // Output register
    logic    r_out_valid;
    t_result r_out_data;

    // Combinational helpers
    logic                 w_in_acc;
    logic                 w_out_free;
    logic [TW-1:0]        w_step;
    logic [TW-1:0]        w_dt;
    logic                 w_g_before;
    logic [GW-1:0]        w_dg;
    logic signed [VW:0]   w_dv;
    logic [VW-1:0]        w_dvm;
    logic [GW-1:0]        w_mul_x;
    logic [VW-1:0]        w_mul_y;
    logic [PW-1:0]        w_mul;
    logic [PW:0]          w_cap_sum;
    logic [MAX_OUT_W:0]   w_cap_cnt;
    logic                 w_cap;
    logic                 w_more;
    logic [GW-1:0]        w_high;
    logic [TW:0]          w_dsh;
    logic                 w_dge;
    logic [TW:0]          w_ddiff;
    logic [QB-1:0]        w_q;
    logic signed [RW-1:0] w_v0x;
    logic signed [RW-1:0] w_qx;
    logic signed [RW-1:0] w_sum;
    logic signed [VW-1:0] w_sat;
    logic [GW:0]          n_grid;
    logic                 w_last;
    logic [TW-1:0]        w_rest;

    assign w_in_acc   = i_point.valid && i_point.ready;
    assign w_out_free = !r_out_valid || o_result.ready;

    // Grid step, zero treated as one
    assign w_step = (r_step[TW-1:0] == '0) ? TW'(1) : r_step[TW-1:0];

    // Segment geometry
    assign w_dt       = r_t1 - r_prev_time;
    assign w_g_before = r_grid < GW'(r_prev_time);
    assign w_dg       = w_g_before ? (GW'(r_prev_time) - r_grid) : (r_grid - GW'(r_prev_time));
    assign w_dv       = (VW+1)'(r_v1) - (VW+1)'(r_prev_value);
    assign w_dvm      = w_dv[VW] ? VW'(-w_dv) : w_dv[VW-1:0];

    // Shared multiplier: cap lookahead in EVAL, |dv| * |dg| otherwise
    assign w_mul_x = (r_state == S_EVAL) ? GW'(w_step) : w_dg;
    assign w_mul_y = (r_state == S_EVAL) ? VW'(MAX_PER_SEGMENT) : w_dvm;
    assign w_mul   = w_mul_x * w_mul_y;

    // Run gets capped if a full run still leaves a due grid time and room in the record
    assign w_cap_sum = (PW+1)'(r_grid) + (PW+1)'(r_prod);
    assign w_cap_cnt = (MAX_OUT_W+1)'(r_count) + (MAX_OUT_W+1)'(MAX_PER_SEGMENT);
    assign w_cap     = (w_cap_sum <= (PW+1)'(r_t1)) && (w_cap_cnt < (MAX_OUT_W+1)'(r_max));

    // Another output due on this point
    assign w_more = (r_grid <= GW'(r_t1)) && (r_count < r_max) &&
                    (r_n < MW'(MAX_PER_SEGMENT));

    // Restoring divider, one quotient bit per cycle
    assign w_high  = r_num[NW-1:QB];
    assign w_dsh   = {r_rem, r_sh[SW-1]};
    assign w_dge   = w_dsh >= {1'b0, r_den};
    assign w_ddiff = w_dsh - {1'b0, r_den};

    // Signed result and clamp to the value range
    assign w_q   = r_ovf ? '1 : r_quo;
    assign w_v0x = RW'(r_prev_value);
    assign w_qx  = $signed(RW'(w_q));
    assign w_sum = r_neg ? (w_v0x - w_qx) : (w_v0x + w_qx);
    assign w_sat = (w_sum > VMAX) ? VMAX[VW-1:0] :
                   (w_sum < VMIN) ? VMIN[VW-1:0] : w_sum[VW-1:0];

    // Grid advance and end-of-run detection
    assign n_grid = (GW+1)'(r_grid) + (GW+1)'(w_step);
    assign w_last = (n_grid > (GW+1)'(r_t1)) ||
                    ((MAX_OUT_W+1)'(r_count) + 1'b1 == (MAX_OUT_W+1)'(r_max)) ||
                    ((MW+1)'(r_n) + 1'b1 == (MW+1)'(MAX_PER_SEGMENT));

    // Distance left to cover when skipping capped grid times
    assign w_rest = r_t1 - r_grid[TW-1:0];

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= START_TIME_RST;
            r_step  <= STEP_TIME_RST;
            r_max   <= MAX_OUTPUTS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_TIME:  r_start <= i_cfg_wdata;
                CFG_STEP_TIME:   r_step  <= i_cfg_wdata;
                CFG_MAX_OUTPUTS: r_max   <= i_cfg_wdata[MAX_OUT_W-1:0];
                default: ;
            endcase
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_OUT && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && w_out_free) begin
            r_out_data.out_value   <= OUT_VALUE_W'(r_res);
            r_out_data.out_index   <= r_count;
            r_out_data.last_of_run <= w_last;
            r_out_data.cap_hit     <= r_cap;
        end
    end

    // Sequencer control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_have_prev <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_in_acc) r_state <= S_EVAL;
                end
                S_EVAL: begin
                    if (r_first || !r_have_prev || r_t1 < r_prev_time) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_CAP;
                    end
                    r_have_prev <= 1'b1;
                end
                S_CAP: r_state <= S_TEST;
                S_TEST: begin
                    if (w_more) begin
                        r_state <= (w_dt == '0) ? S_OUT : S_ADD;
                    end else if (r_cap) begin
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_ADD: r_state <= S_CHK;
                S_CHK: r_state <= (w_high >= GW'(w_dt)) ? S_RES : S_DIV;
                S_DIV: begin
                    if (r_dcnt == CW'(1)) r_state <= r_skip ? S_SKIP : S_RES;
                end
                S_RES: r_state <= S_OUT;
                S_OUT: begin
                    if (w_out_free) r_state <= S_TEST;
                end
                S_SKIP: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Sequencer datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    r_t1    <= i_point.data.point_time[TW-1:0];
                    r_v1    <= i_point.data.point_value[VW-1:0];
                    r_first <= i_point.data.first_point;
                end
            end
            S_EVAL: begin
                // New record, or time went backwards: just take the point
                if (r_first || !r_have_prev) begin
                    r_prev_time  <= r_t1;
                    r_prev_value <= r_v1;
                    r_grid       <= GW'(r_start[TW-1:0]);
                    r_count      <= '0;
                end else if (r_t1 < r_prev_time) begin
                    r_prev_time  <= r_t1;
                    r_prev_value <= r_v1;
                end
                r_prod <= w_mul;
                r_n    <= '0;
            end
            S_CAP: r_cap <= w_cap;
            S_TEST: begin
                if (w_more) begin
                    r_res  <= r_v1;
                    r_prod <= w_mul;
                    r_neg  <= w_g_before ^ w_dv[VW];
                end else begin
                    // Run over: load remainder pass for the skip, take the point
                    r_skip       <= 1'b1;
                    r_rem        <= '0;
                    r_den        <= w_step;
                    r_sh         <= SW'(w_rest) << (SW - TW);
                    r_dcnt       <= CW'(TW);
                    r_prev_time  <= r_t1;
                    r_prev_value <= r_v1;
                end
            end
            S_ADD: r_num <= NW'(r_prod) + NW'(w_dt >> 1);
            S_CHK: begin
                r_ovf  <= w_high >= GW'(w_dt);
                r_skip <= 1'b0;
                r_rem  <= w_high[TW-1:0];
                r_den  <= w_dt;
                r_sh   <= SW'(r_num[QB-1:0]) << (SW - QB);
                r_dcnt <= CW'(QB);
            end
            S_DIV: begin
                r_rem  <= w_dge ? w_ddiff[TW-1:0] : w_dsh[TW-1:0];
                r_sh   <= r_sh << 1;
                r_quo  <= {r_quo[QB-2:0], w_dge};
                r_dcnt <= r_dcnt - 1'b1;
            end
            S_RES: r_res <= w_sat;
            S_OUT: begin
                if (w_out_free) begin
                    r_grid  <= n_grid[GW-1:0];
                    r_count <= r_count + 1'b1;
                    r_n     <= r_n + 1'b1;
                end
            end
            // First grid time after the point: t1 - ((t1 - g) mod step) + step
            S_SKIP: r_grid <= GW'(r_t1) - GW'(r_rem) + GW'(w_step);
            default: ;
        endcase
    end

    assign i_point.ready  = (r_state == S_IDLE);
    assign o_result.valid = r_out_valid;
    assign o_result.data  = r_out_data;

    // An accepted item always goes to evaluation next
    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_state == S_EVAL)
        else $error("accepted item not evaluated");

    // Divider remainder stays below the divisor
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIV |-> r_rem < r_den)
        else $error("divider remainder out of range");

    // No output is loaded once the record limit is reached
    a_rec_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && w_out_free) |-> r_count < r_max)
        else $error("output beyond max_outputs");

    // Per-point output count never passes the cap
    a_seg_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> r_n < MW'(MAX_PER_SEGMENT))
        else $error("output beyond per-point cap");

endmodule

// ===== sim/tb_linear_interp_resampler_core.sv =====
// Self-checking testbench for the linear interpolation resampler core.
`timescale 1ns / 1ps

module tb_linear_interp_resampler_core;
    import lir_pkg::*;

    localparam int      RUN_CAP        = 64;     // outputs allowed per point
    localparam int      SETTLE_CYCLES  = 120;    // covers a trailing grid skip
    localparam int      DRAIN_CYCLES   = 200;
    localparam int      WATCHDOG_LIMIT = 5000;
    localparam longint  VAL_MAX        = 64'sd2147483647;
    localparam longint  VAL_MIN        = -VAL_MAX - 1;
    localparam logic [127:0] QUO_CAP   = 128'd1 << 40;

    logic clk;
    logic rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    lir_point_if  pt_if();
    lir_result_if res_if();

    linear_interp_resampler_core #(
        .MAX_PER_SEGMENT(RUN_CAP)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_point    (pt_if),
        .o_result   (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_wdata(cfg_wdata)
    );

    // Shadow of the register file
    logic [31:0] cfg_start   = START_TIME_RST;
    logic [31:0] cfg_step    = STEP_TIME_RST;
    logic [15:0] cfg_max_out = MAX_OUTPUTS_RST;

    // Shadow of the resampler state
    logic [31:0]        seg_time   = '0;
    logic signed [31:0] seg_value  = '0;
    logic [48:0]        grid_time  = '0;
    logic [15:0]        out_count  = '0;
    bit                 seg_open   = 1'b0;

    t_result pending_samples[$];

    int error_count  = 0;
    int quiet_cycles = 0;
    int stall_left   = 0;
    bit idle_en      = 1'b1;

    // Clock
    initial begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Value on the line through (t0,v0) and (t1,v1) at grid time g,
    // rounded half away from zero and clamped to the 32-bit range
    function automatic logic signed [31:0] line_value(input logic [48:0] g,
                                                      input logic [31:0] t0,
                                                      input logic signed [31:0] v0,
                                                      input logic [31:0] t1,
                                                      input logic signed [31:0] v1);
        logic [31:0]  span;
        logic [48:0]  reach;
        logic [32:0]  rise;
        logic [127:0] quo;
        bit           neg;
        longint       dv;
        longint       res;
        span = t1 - t0;
        if (span == 0)
            return v1;
        if (g >= {17'd0, t0}) begin
            reach = g - t0;
            neg   = 1'b0;
        end else begin
            reach = {17'd0, t0} - g;
            neg   = 1'b1;
        end
        dv = longint'(v1) - longint'(v0);
        if (dv < 0) begin
            rise = 33'(-dv);
            neg  = !neg;
        end else begin
            rise = 33'(dv);
        end
        quo = (128'(rise) * 128'(reach) + 128'(span >> 1)) / 128'(span);
        if (quo > QUO_CAP)
            quo = QUO_CAP;
        res = longint'(v0) + (neg ? -longint'(quo[40:0]) : longint'(quo[40:0]));
        if (res > VAL_MAX) res = VAL_MAX;
        if (res < VAL_MIN) res = VAL_MIN;
        return res[31:0];
    endfunction

    // Work out the grid outputs an accepted point causes and queue them
    function automatic void predict_grid_outputs(input t_point p);
        t_result     run[$];
        t_result     r;
        logic [48:0] stride;
        logic [48:0] pt;
        bit          cut;
        stride = (cfg_step == 0) ? 49'd1 : 49'(cfg_step);
        pt     = 49'(p.point_time);
        // record start: remember the point, restart the grid
        if (p.first_point || !seg_open) begin
            seg_time  = p.point_time;
            seg_value = p.point_value;
            grid_time = 49'(cfg_start);
            out_count = '0;
            seg_open  = 1'b1;
            return;
        end
        // points going back in time only replace the previous point
        if (p.point_time >= seg_time) begin
            while (grid_time <= pt && out_count < cfg_max_out && run.size() < RUN_CAP) begin
                r.out_value   = line_value(grid_time, seg_time, seg_value,
                                           p.point_time, p.point_value);
                r.out_index   = out_count;
                r.last_of_run = 1'b0;
                r.cap_hit     = 1'b0;
                run.push_back(r);
                grid_time += stride;
                out_count++;
            end
            // per-point cap: skip what is still due up to this point
            cut = (run.size() == RUN_CAP) && (grid_time <= pt) && (out_count < cfg_max_out);
            if (cut)
                grid_time += ((pt - grid_time) / stride + 49'd1) * stride;
            foreach (run[k])
                run[k].cap_hit = cut;
            if (run.size() > 0)
                run[run.size() - 1].last_of_run = 1'b1;
            foreach (run[k])
                pending_samples.push_back(run[k]);
        end
        seg_time  = p.point_time;
        seg_value = p.point_value;
    endfunction

    // Output side: random stall bursts on ready
    always @(negedge clk) begin
        if (stall_left > 0) begin
            res_if.ready <= 1'b0;
            stall_left--;
        end else if (idle_en && $urandom_range(0, 7) == 0) begin
            res_if.ready <= 1'b0;
            stall_left = $urandom_range(0, 12);
        end else begin
            res_if.ready <= 1'b1;
        end
    end

    // Compare each accepted output with the oldest prediction
    always @(posedge clk) begin : check_outputs
        t_result got;
        t_result want;
        if (rst_n && res_if.valid && res_if.ready) begin
            got = res_if.data;
            if (pending_samples.size() == 0) begin
                report_mismatch($sformatf("unexpected output value %0d index %0d",
                                          got.out_value, got.out_index));
            end else begin
                want = pending_samples.pop_front();
                if (got.out_value !== want.out_value)
                    report_mismatch($sformatf("index %0d: out_value %0d, want %0d",
                                              want.out_index, got.out_value, want.out_value));
                if (got.out_index !== want.out_index)
                    report_mismatch($sformatf("out_index %0d, want %0d",
                                              got.out_index, want.out_index));
                if (got.last_of_run !== want.last_of_run)
                    report_mismatch($sformatf("index %0d: last_of_run %0b, want %0b",
                                              want.out_index, got.last_of_run,
                                              want.last_of_run));
                if (got.cap_hit !== want.cap_hit)
                    report_mismatch($sformatf("index %0d: cap_hit %0b, want %0b",
                                              want.out_index, got.cap_hit, want.cap_hit));
            end
        end
    end

    // Watchdog on cycles with no item moving on either side
    always @(posedge clk) begin
        if ((pt_if.valid && pt_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("TIMEOUT: no item accepted for %0d cycles", WATCHDOG_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Send one point, with an optional idle burst in front of it
    task automatic send_point(input logic [31:0] t, input logic [31:0] v, input bit first);
        t_point p;
        int     gap;
        p.point_time  = t;
        p.point_value = v;
        p.first_point = first;
        @(negedge clk);
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 13);
            pt_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pt_if.valid <= 1'b1;
        pt_if.data  <= p;
        @(posedge clk);
        while (!pt_if.ready) @(posedge clk);
        predict_grid_outputs(p);
    endtask

    // Stop sending and let the block run dry
    task automatic settle_block();
        @(negedge clk);
        pt_if.valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        case (idx)
            CFG_START_TIME:  cfg_start   = value;
            CFG_STEP_TIME:   cfg_step    = value;
            CFG_MAX_OUTPUTS: cfg_max_out = value[15:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Register defaults: plain interpolation, a point back in time, value extremes
    task automatic test_defaults();
        send_point(32'h0000_0000, 32'd0, 1'b1);
        send_point(32'h0000_0500, 32'd1000, 1'b0);
        send_point(32'h0000_0400, 32'd7, 1'b0);
        send_point(32'h0000_0680, 32'h8000_0000, 1'b0);
        send_point(32'h0000_0680, 32'h7FFF_FFFF, 1'b0);
    endtask

    // Grid before the first point, zero-width segment, saturation, per-point cap
    task automatic test_extrapolation();
        send_point(32'h0000_0300, 32'd50, 1'b1);
        send_point(32'h0000_0300, -32'sd20, 1'b0);
        send_point(32'h0000_1000, 32'h7FFF_FFFF, 1'b1);
        send_point(32'h0000_1001, 32'h8000_0000, 1'b0);
        send_point(32'hFFFF_FFFF, 32'd0, 1'b0);
    endtask

    // Register extremes: widest step, zero step, output limit and a limit of zero
    task automatic test_output_limits();
        settle_block();
        write_reg(CFG_START_TIME, 32'hFFFF_FFFF);
        write_reg(CFG_STEP_TIME, 32'hFFFF_FFFF);
        write_reg(CFG_MAX_OUTPUTS, 32'd3);
        send_point(32'hFFFF_FF00, 32'hFFFF_FFFF, 1'b1);
        send_point(32'hFFFF_FFFF, 32'd1, 1'b0);

        settle_block();
        write_reg(CFG_START_TIME, 32'h0000_0010);
        write_reg(CFG_STEP_TIME, 32'd0);
        send_point(32'h0000_0010, 32'd100, 1'b1);
        send_point(32'h0000_0020, 32'd200, 1'b0);
        send_point(32'h0000_0030, 32'd300, 1'b0);

        settle_block();
        write_reg(CFG_MAX_OUTPUTS, 32'd0);
        send_point(32'h0000_0000, 32'd0, 1'b1);
        send_point(32'h0000_1000, 32'd5, 1'b0);
    endtask

    // Random settings, then mostly well-formed records with some noise
    task automatic test_random_phase(input int n_items, input bit with_idle);
        logic [31:0]     st;
        logic [31:0]     v;
        longint unsigned stride;
        longint unsigned t_cur;
        longint unsigned reach;
        int              pick;
        bit              first;
        settle_block();
        idle_en = with_idle;
        case ($urandom_range(0, 3))
            0:       st = $urandom_range(1, 64);
            1:       st = 32'd256;
            2:       st = $urandom_range(257, 65536);
            default: st = $urandom;
        endcase
        write_reg(CFG_STEP_TIME, st);
        write_reg(CFG_START_TIME, $urandom_range(0, 1) ? $urandom : $urandom_range(0, 4096));
        case ($urandom_range(0, 3))
            0:       write_reg(CFG_MAX_OUTPUTS, $urandom_range(0, 40));
            1:       write_reg(CFG_MAX_OUTPUTS, $urandom_range(0, 65535));
            default: write_reg(CFG_MAX_OUTPUTS, 32'h0000_FFFF);
        endcase
        stride = (st == 0) ? 1 : st;
        t_cur  = cfg_start;
        for (int i = 0; i < n_items; i++) begin
            pick = $urandom_range(0, 99);
            if (i == 0 || pick < 8) begin
                // new record near the first grid time, either side of it
                first = 1'b1;
                t_cur = cfg_start;
                reach = stride * $urandom_range(0, 2) + $urandom_range(0, 255);
                if ($urandom_range(0, 1))
                    t_cur = t_cur + reach;
                else
                    t_cur = (reach > t_cur) ? 0 : t_cur - reach;
            end else if (pick < 14) begin
                first = $urandom_range(0, 1);
                t_cur = $urandom;
            end else if (pick < 16) begin
                // long jump, may run into the per-point cap
                first = 1'b0;
                t_cur = t_cur + stride * $urandom_range(60, 90);
            end else begin
                first = 1'b0;
                t_cur = t_cur + stride * $urandom_range(0, 2) + longint'($urandom) % stride;
            end
            t_cur = t_cur & 64'hFFFF_FFFF;
            v = $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 2000)) - 32'd1000;
            send_point(t_cur[31:0], v, first);
        end
    endtask

    initial begin
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_idx      = '0;
        cfg_wdata    = '0;
        pt_if.valid  = 1'b0;
        pt_if.data   = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_defaults();
        test_extrapolation();
        test_output_limits();
        for (int ph = 0; ph < 4; ph++)
            test_random_phase(40, 1'b1);
        test_random_phase(40, 1'b0);

        // drain
        @(negedge clk);
        pt_if.valid <= 1'b0;
        while (pending_samples.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
